// ----- rtl/pqms_pkg.sv -----
// Shared types, sizes and the entry ordering for the max-select priority queue.
package pqms_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] item_value;
    logic signed [31:0] item_priority;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] best_value;
    logic signed [31:0] best_priority;
    logic [CNT_W-1:0]   occupancy;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] prio;
    logic signed [31:0] value;
  } entry_t;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_SHIFT  = 2'd2
  } cell_cmd_t;

  // Broadcast to every cell of the chain in the same cycle.
  typedef struct packed {
    cell_cmd_t cmd;
    entry_t    item;
  } cell_ctl_t;

  // True when a ranks at or above b: higher priority, then larger value.
  function automatic logic entry_ge(input entry_t a, input entry_t b);
    logic res;
    begin
      if (a.prio != b.prio) begin
        res = (a.prio > b.prio);
      end else begin
        res = (a.value >= b.value);
      end
      return res;
    end
  endfunction

endpackage

// ----- rtl/pqms_cell.sv -----
// One slot of the sorted chain: holds an entry, inserts or shifts with its neighbors.
module pqms_cell
  import pqms_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occ,
  input  logic      upper_ge,
  input  entry_t    upper_ent,
  input  entry_t    lower_ent,
  output entry_t    ent,
  output logic      ge
);

  // Flag that this slot stays ahead of the incoming entry.
  assign ge = occ && entry_ge(ent, ctl.item);

  // Keep, take the new entry, or take a neighbor's entry.
  always_ff @(posedge clk) begin
    unique case (ctl.cmd)
      CMD_INSERT: begin
        if (!ge) begin
          ent <= upper_ge ? ctl.item : upper_ent;
        end
      end
      CMD_SHIFT: begin
        ent <= lower_ent;
      end
      default: begin
        ent <= ent;
      end
    endcase
  end

endmodule

// ----- rtl/priority_queue_max_select.sv -----
// Top level of the max-select priority queue: sorted cell chain and result register.
//
// Usage: each input beat on in_item is one operation (enqueue, dequeue, peek, no-op).
// A beat is taken when in_valid is high and in_stall is low; every taken beat
// produces exactly one result beat on out_item, taken when out_valid is high
// and out_stall is low.
// Entries are kept sorted in a chain of DEPTH cells, best entry in cell 0, so
// a peek reads cell 0, a dequeue shifts the chain up by one slot, and an
// enqueue lets every cell compare itself against the new entry and open a
// gap in the same cycle.
// The result is registered and appears the cycle after its operation is taken.
// One operation is taken per cycle while the result is not stalled, with the
// compare in each cell combinational and the one result register.
// Reset (rst, synchronous) empties the queue and drops any pending result.
// While the receiver stalls, the result beat holds and in_stall rises, so no
// further operation is taken until the result is delivered.
// Empty peek/dequeue and full enqueue report a status and leave the queue as is.
module priority_queue_max_select
  import pqms_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             in_take;
  cell_ctl_t        ctl;
  out_item_t        res;
  entry_t           ent [DEPTH];
  logic             ge  [DEPTH];

  assign in_stall = out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  // Decode the operation against the current fill level.
  always_comb begin
    ctl.cmd           = CMD_HOLD;
    ctl.item.prio     = in_item.item_priority;
    ctl.item.value    = in_item.item_value;
    count_next        = count;
    res.status        = ST_OK;
    res.best_value    = '0;
    res.best_priority = '0;
    unique case (in_item.op)
      OP_ENQ: begin
        if (count == CNT_W'(DEPTH)) begin
          res.status = ST_FULL;
        end else begin
          ctl.cmd    = CMD_INSERT;
          count_next = count + 1'b1;
        end
      end
      OP_DEQ, OP_PEEK: begin
        if (count == '0) begin
          res.status = ST_EMPTY;
        end else begin
          res.best_value    = ent[0].value;
          res.best_priority = ent[0].prio;
          if (in_item.op == OP_DEQ) begin
            ctl.cmd    = CMD_SHIFT;
            count_next = count - 1'b1;
          end
        end
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
    res.occupancy = count_next;
    if (!in_take) begin
      ctl.cmd = CMD_HOLD;
    end
  end

  // Build the chain; cell 0 has nothing above, the last cell nothing below.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   occ;
    logic   up_ge;
    entry_t up_ent;
    entry_t lo_ent;

    assign occ = (count > CNT_W'(i));
    if (i == 0) begin : g_top
      assign up_ge  = 1'b1;
      assign up_ent = ctl.item;
    end else begin : g_mid
      assign up_ge  = ge[i-1];
      assign up_ent = ent[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign lo_ent = '0;
    end else begin : g_lo
      assign lo_ent = ent[i+1];
    end

    pqms_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (occ),
      .upper_ge  (up_ge),
      .upper_ent (up_ent),
      .lower_ent (lo_ent),
      .ent       (ent[i]),
      .ge        (ge[i])
    );
  end

  // Advance the fill level on each taken beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_take) begin
      count <= count_next;
    end
  end

  // Hold the result beat until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_item <= res;
    end
  end

endmodule

// ----- rtl/pqms_checker.sv -----
// Port-level checks for the max-select priority queue, bound to the top level.
module pqms_checker
  import pqms_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result beat changed while stalled");

  // Every taken operation yields a result on the next cycle.
  a_in_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("taken operation produced no result");

  // Flagged results carry zero payload.
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status != ST_OK |->
      out_item.best_value == '0 && out_item.best_priority == '0)
    else $error("flagged result with nonzero payload");

  // Empty and full flags agree with the reported occupancy.
  a_flag_occ: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      (out_item.status != ST_EMPTY || out_item.occupancy == '0) &&
      (out_item.status != ST_FULL || out_item.occupancy == CNT_W'(DEPTH)) &&
      (out_item.occupancy <= CNT_W'(DEPTH)))
    else $error("status and occupancy disagree");

endmodule

bind priority_queue_max_select pqms_checker u_pqms_checker (.*);

// ----- test/tb.sv -----
// Testbench for priority_queue_max_select: scoreboard class, driver tasks and run control.
module tb;
  import pqms_pkg::*;

  // Track held entries and the results they imply.
  class pq_scoreboard;
    logic signed [31:0] held_value [DEPTH];
    logic signed [31:0] held_prio  [DEPTH];
    int unsigned        held_count;
    out_item_t          awaited [$];
    int                 errors;

    function new();
      held_count = 0;
      errors     = 0;
    endfunction

    // Predict the result of one taken operation and update the held entries.
    function void note_op(in_item_t it);
      out_item_t   r;
      int unsigned top;
      r        = '0;
      r.status = ST_OK;
      case (it.op)
        OP_ENQ: begin
          if (held_count >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            held_value[held_count] = it.item_value;
            held_prio[held_count]  = it.item_priority;
            held_count++;
          end
        end
        OP_DEQ, OP_PEEK: begin
          if (held_count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            // scan from the first entry: higher priority, then larger value;
            // the earliest one wins a full tie
            top = 0;
            for (int unsigned i = 1; i < held_count; i++) begin
              if (held_prio[i] > held_prio[top] ||
                  (held_prio[i] == held_prio[top] && held_value[i] > held_value[top])) begin
                top = i;
              end
            end
            r.best_value    = held_value[top];
            r.best_priority = held_prio[top];
            // close the gap behind the removed entry
            if (it.op == OP_DEQ) begin
              for (int unsigned i = top; i + 1 < held_count; i++) begin
                held_value[i] = held_value[i + 1];
                held_prio[i]  = held_prio[i + 1];
              end
              held_count--;
            end
          end
        end
        default: begin
        end
      endcase
      r.occupancy = CNT_W'(held_count);
      awaited.push_back(r);
    endfunction

    // Compare one delivered result with the oldest prediction.
    function void check_result(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        $error("result beat with nothing awaited: status %0d value %0d prio %0d occ %0d",
               got.status, got.best_value, got.best_priority, got.occupancy);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.best_value !== want.best_value) begin
        $error("best_value: expected %0d, got %0d", want.best_value, got.best_value);
        errors++;
      end
      if (got.best_priority !== want.best_priority) begin
        $error("best_priority: expected %0d, got %0d", want.best_priority, got.best_priority);
        errors++;
      end
      if (got.occupancy !== want.occupancy) begin
        $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
        errors++;
      end
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  int idle_pct  = 0;
  int stall_pct = 0;

  pq_scoreboard sb = new();

  priority_queue_max_select uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Take result beats and stall at random.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(out_item);
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic in_item_t mk_op(op_t op, logic [31:0] v, logic [31:0] p);
    in_item_t it;
    it.op            = op;
    it.item_value    = v;
    it.item_priority = p;
    return it;
  endfunction

  // Mix full-range words with small ones (for ties) and the extremes.
  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    case ($urandom_range(3))
      0: begin
        w = $urandom_range(6);
        w = w - 32'd3;
      end
      1: begin
        case ($urandom_range(3))
          0:       w = 32'h8000_0000;
          1:       w = 32'h7fff_ffff;
          2:       w = 32'h0000_0000;
          default: w = 32'hffff_ffff;
        endcase
      end
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // Present one operation beat, idling first at random, and hold it until taken.
  task automatic push_op(in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    sb.note_op(it);
  endtask

  // Hold off the sender until every awaited result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Run bursts that lean toward filling, draining or a mix.
  task automatic run_phase(int n);
    int   left;
    int   mode;
    int   len;
    int   r;
    op_t  op;
    left = n;
    while (left > 0) begin
      mode = $urandom_range(3);
      len  = $urandom_range(40, 8);
      for (int k = 0; k < len && left > 0; k++) begin
        r = $urandom_range(99);
        case (mode)
          0: begin
            op = (r < 70) ? OP_ENQ : (r < 85) ? OP_DEQ : (r < 97) ? OP_PEEK : OP_NOP;
          end
          1: begin
            op = (r < 20) ? OP_ENQ : (r < 80) ? OP_DEQ : (r < 97) ? OP_PEEK : OP_NOP;
          end
          default: begin
            op = (r < 45) ? OP_ENQ : (r < 80) ? OP_DEQ : (r < 97) ? OP_PEEK : OP_NOP;
          end
        endcase
        push_op(mk_op(op, pick_word(), pick_word()));
        left--;
      end
    end
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty queue on peek and dequeue, no-op code while empty
    push_op(mk_op(OP_PEEK, 32'h0, 32'h0));
    push_op(mk_op(OP_DEQ, 32'h1234_5678, 32'h8765_4321));
    push_op(mk_op(OP_NOP, 32'h5a5a_5a5a, 32'ha5a5_a5a5));

    // lowest priority entries are still selected; larger value wins the tie
    push_op(mk_op(OP_ENQ, 32'h7fff_ffff, 32'h8000_0000));
    push_op(mk_op(OP_ENQ, 32'h8000_0000, 32'h8000_0000));
    push_op(mk_op(OP_PEEK, 32'hffff_ffff, 32'hffff_ffff));

    // duplicates, equal priorities and the top priority
    push_op(mk_op(OP_ENQ, 32'd7, 32'd3));
    push_op(mk_op(OP_ENQ, 32'd7, 32'd3));
    push_op(mk_op(OP_ENQ, 32'd9, 32'd3));
    push_op(mk_op(OP_ENQ, 32'hffff_ffff, 32'hffff_ffff));
    push_op(mk_op(OP_ENQ, 32'h0, 32'h7fff_ffff));
    push_op(mk_op(OP_ENQ, 32'h8000_0000, 32'h7fff_ffff));
    for (int k = 0; k < 8; k++) begin
      push_op(mk_op(OP_ENQ, $urandom, $urandom));
    end

    // full queue on enqueue, no-op while full, then pull the best few
    push_op(mk_op(OP_ENQ, 32'd1, 32'd1));
    push_op(mk_op(OP_NOP, 32'h0, 32'h0));
    repeat (3) push_op(mk_op(OP_DEQ, 32'h0, 32'h0));
    drain();

    idle_pct  = 0;
    stall_pct = 0;
    run_phase(480);
    idle_pct  = 78;
    stall_pct = 0;
    run_phase(480);
    idle_pct  = 0;
    stall_pct = 78;
    run_phase(480);
    idle_pct  = 34;
    stall_pct = 34;
    run_phase(480);

    // let any stray beat show up before the verdict
    stall_pct = 0;
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #5000000;
    $display("tb: errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/pqms_pkg.sv
rtl/pqms_cell.sv
rtl/priority_queue_max_select.sv
rtl/pqms_checker.sv
test/tb.sv
